// ----- hdl/gis_pkg.sv -----
// shared types and constants for the generational id sparse set
// used by gis_dense_store and generational_id_sparse_set_unit, no dependencies
package gis_pkg;

   localparam int IdW      = 12;
   localparam int GenW     = 16;
   localparam int SlotW    = 13;
   localparam int CntW     = 7;
   localparam int MaxIds   = 4096;
   localparam int MaxBatch = 64;
   localparam int DenseDepth = MaxIds + 1;

   typedef enum logic [2:0] {
      OP_NEW_ID     = 3'd0,
      OP_NEW_IDS    = 3'd1,
      OP_ENSURE     = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_LOOKUP     = 3'd4,
      OP_MAKE_ALIVE = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef struct packed {
      logic [GenW-1:0] gen;
      logic [IdW-1:0]  id;
   } word_type;

   typedef struct packed {
      logic             we;
      logic [SlotW-1:0] waddr;
      word_type         wdata;
      logic [SlotW-1:0] raddr;
   } dense_port_type;

endpackage

// ----- hdl/gis_dense_store.sv -----
// dense store of entity words, one write and one registered read per cycle
// depends on gis_pkg
module gis_dense_store (
   input  logic                    clock,
   input  gis_pkg::dense_port_type port,
   output gis_pkg::word_type       rd_data
);

   gis_pkg::word_type mem [gis_pkg::DenseDepth];

   always_ff @(posedge clock) begin
      if (port.we) begin
         mem[port.waddr] <= port.wdata;
      end
      rd_data <= mem[port.raddr];
   end

endmodule

// ----- hdl/generational_id_sparse_set_unit.sv -----
// Sparse set of generation-tagged ids. One transaction at a time; each step of a
// transaction is at most one write and one registered read of each of the sparse
// and dense stores, both of which have a separate write port and read port. After
// reset the sparse store is swept to zero, all 4096 entries, before req_tready
// rises; clear repeats that sweep.
// depends on gis_pkg and gis_dense_store
module generational_id_sparse_set_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, entity_id, entity_generation, batch_count, zero pad
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_id, out_generation, alive_flag, exists_flag, valid_flag,
   // alive_total, dead_total, zero pad
   output logic [55:0] rsp_tdata,
   // status
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_CLR      = 17'h00002,
      ST_OP_S     = 17'h00004,
      ST_OP_D     = 17'h00008,
      ST_OP_D2    = 17'h00010,
      ST_OP_W1    = 17'h00020,
      ST_OP_W2    = 17'h00040,
      ST_REP_S    = 17'h00080,
      ST_REP_D    = 17'h00100,
      ST_REP_E    = 17'h00200,
      ST_NEW_A    = 17'h00400,
      ST_NEW_B    = 17'h00800,
      ST_BAT_CHK  = 17'h01000,
      ST_BAT_MINT = 17'h02000,
      ST_BAT_RD   = 17'h04000,
      ST_BAT_Q    = 17'h08000,
      ST_OUT      = 17'h10000
   } state_type;

   localparam int IdW   = gis_pkg::IdW;
   localparam int GenW  = gis_pkg::GenW;
   localparam int SlotW = gis_pkg::SlotW;
   localparam int CntW  = gis_pkg::CntW;

   state_type          state_ff, state_in;
   gis_pkg::op_type    op_ff, op_in;
   logic [IdW-1:0]     id_ff, id_in;
   logic [GenW-1:0]    gen_ff, gen_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [SlotW-1:0]   am_ff, am_in, du_ff, du_in;
   logic [IdW-1:0]     hi_ff, hi_in;
   logic [SlotW-1:0]   s_ff, s_in, nc_ff, nc_in, idx_ff, idx_in;
   gis_pkg::word_type  w_ff, w_in;
   logic               do_ff, do_in;
   logic [IdW-1:0]     clr_ff, clr_in;
   logic               clr_rsp_ff, clr_rsp_in;

   gis_pkg::word_type  rsp_w_ff, rsp_w_in;
   logic               rsp_alive_ff, rsp_alive_in;
   logic               rsp_exists_ff, rsp_exists_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   // sparse store
   logic [SlotW-1:0]   sp_mem [gis_pkg::MaxIds];
   logic               sp_we;
   logic [IdW-1:0]     sp_waddr, sp_raddr;
   logic [SlotW-1:0]   sp_wdata, sp_q;

   gis_pkg::dense_port_type dn_port;
   gis_pkg::word_type       dn_q;

   logic [SlotW-1:0]   s_comb, slot, nc;
   logic [CntW-1:0]    cnt_sat;
   logic [SlotW-1:0]   to_add, mint_top;
   gis_pkg::word_type  in_word, sw;
   logic               skip;

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_mem[sp_waddr] <= sp_wdata;
      end
      sp_q <= sp_mem[sp_raddr];
   end

   gis_dense_store u_dense (
      .clock   (clock),
      .port    (dn_port),
      .rd_data (dn_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, IdW'(du_ff - am_ff), IdW'(am_ff - SlotW'(1)),
                        rsp_valid_ff, rsp_exists_ff, rsp_alive_ff,
                        rsp_w_ff.gen, rsp_w_ff.id};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign in_word = '{gen: gen_ff, id: id_ff};
   assign s_comb  = (id_ff == '0) ? '0 : sp_q;
   assign cnt_sat = (cnt_ff > CntW'(gis_pkg::MaxBatch)) ? CntW'(gis_pkg::MaxBatch) : cnt_ff;
   assign nc      = am_ff + SlotW'(cnt_sat);
   assign to_add  = nc - du_ff;
   assign mint_top = {1'b0, hi_ff} + to_add;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      gen_in        = gen_ff;
      cnt_in        = cnt_ff;
      am_in         = am_ff;
      du_in         = du_ff;
      hi_in         = hi_ff;
      s_in          = s_ff;
      nc_in         = nc_ff;
      idx_in        = idx_ff;
      w_in          = w_ff;
      do_in         = do_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_alive_in  = rsp_alive_ff;
      rsp_exists_in = rsp_exists_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      sp_we         = 1'b0;
      sp_waddr      = id_ff;
      sp_wdata      = '0;
      sp_raddr      = id_ff;
      dn_port       = '{we: 1'b0, waddr: '0, wdata: in_word, raddr: am_ff};
      slot          = (s_ff == '0) ? du_ff : s_ff;
      sw            = dn_q;
      skip          = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = gis_pkg::op_type'(req_tdata[2:0]);
               id_in  = req_tdata[14:3];
               gen_in = req_tdata[30:15];
               cnt_in = req_tdata[37:31];
               case (gis_pkg::op_type'(req_tdata[2:0]))
                  gis_pkg::OP_NEW_ID:  state_in = ST_NEW_A;
                  gis_pkg::OP_NEW_IDS: state_in = ST_BAT_CHK;
                  gis_pkg::OP_ENSURE, gis_pkg::OP_REMOVE, gis_pkg::OP_MAKE_ALIVE:
                     state_in = ST_OP_S;
                  gis_pkg::OP_CLEAR: begin
                     am_in      = SlotW'(1);
                     du_in      = SlotW'(1);
                     hi_in      = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  default: state_in = ST_REP_S;
               endcase
            end
         end
         ST_CLR: begin
            sp_we    = 1'b1;
            sp_waddr = clr_ff;
            sp_wdata = '0;
            clr_in   = clr_ff + IdW'(1);
            if (clr_ff == '1) begin
               if (clr_rsp_ff) begin
                  rsp_w_in      = '0;
                  rsp_alive_in  = 1'b0;
                  rsp_exists_in = 1'b0;
                  rsp_valid_in  = 1'b0;
                  rsp_status_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  clr_rsp_in    = 1'b0;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OP_S: state_in = ST_OP_D;
         ST_OP_D: begin
            s_in          = s_comb;
            dn_port.raddr = s_comb;
            state_in      = ST_OP_D2;
         end
         ST_OP_D2: begin
            w_in          = dn_q;
            dn_port.raddr = (op_ff == gis_pkg::OP_REMOVE) ? am_ff - SlotW'(1) : am_ff;
            state_in      = ST_OP_W1;
         end
         ST_OP_W1: begin
            case (op_ff)
               gis_pkg::OP_ENSURE: begin
                  skip = (id_ff == '0) || ((s_ff != '0) && (s_ff < am_ff)) ||
                         ((s_ff == '0) && (du_ff > SlotW'(gis_pkg::MaxIds)));
                  // a freshly placed id sitting right at the alive mark swaps with itself
                  sw = (slot == am_ff) ? in_word : dn_q;
                  if (!skip) begin
                     sp_we         = 1'b1;
                     sp_waddr      = sw.id;
                     sp_wdata      = slot;
                     dn_port.we    = 1'b1;
                     dn_port.waddr = slot;
                     dn_port.wdata = sw;
                     if (s_ff == '0) begin
                        du_in = du_ff + SlotW'(1);
                        if (id_ff > hi_ff) begin
                           hi_in = id_ff;
                        end
                     end
                  end
               end
               gis_pkg::OP_REMOVE: begin
                  skip = (s_ff == '0) || (s_ff >= am_ff) || (w_ff != in_word);
                  if (!skip) begin
                     sp_we         = 1'b1;
                     sp_waddr      = dn_q.id;
                     sp_wdata      = s_ff;
                     dn_port.we    = 1'b1;
                     dn_port.waddr = s_ff;
                     dn_port.wdata = dn_q;
                     am_in         = am_ff - SlotW'(1);
                  end
               end
               default: begin
                  if (s_ff != '0) begin
                     dn_port.we    = 1'b1;
                     dn_port.waddr = s_ff;
                     dn_port.wdata = in_word;
                  end
               end
            endcase
            do_in    = !skip;
            state_in = ST_OP_W2;
         end
         ST_OP_W2: begin
            if (do_ff) begin
               sp_we         = 1'b1;
               sp_waddr      = id_ff;
               sp_wdata      = am_ff;
               dn_port.we    = 1'b1;
               dn_port.waddr = am_ff;
               if (op_ff == gis_pkg::OP_REMOVE) begin
                  dn_port.wdata = '{gen: gen_ff + GenW'(1), id: id_ff};
               end else begin
                  am_in = am_ff + SlotW'(1);
               end
            end
            state_in = ST_REP_S;
         end
         ST_REP_S: state_in = ST_REP_D;
         ST_REP_D: begin
            s_in          = s_comb;
            dn_port.raddr = s_comb;
            state_in      = ST_REP_E;
         end
         ST_REP_E: begin
            rsp_status_in = 1'b0;
            rsp_last_in   = 1'b1;
            if (s_ff == '0) begin
               rsp_w_in      = '0;
               rsp_alive_in  = 1'b0;
               rsp_exists_in = 1'b0;
               rsp_valid_in  = 1'b1;
            end else begin
               rsp_w_in      = dn_q;
               rsp_exists_in = 1'b1;
               rsp_valid_in  = (s_ff < am_ff);
               rsp_alive_in  = (s_ff < am_ff) && (dn_q == in_word);
            end
            state_in = ST_OUT;
         end
         ST_NEW_A: state_in = ST_NEW_B;
         ST_NEW_B: begin
            rsp_alive_in  = 1'b1;
            rsp_exists_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_last_in   = 1'b1;
            if (am_ff != du_ff) begin
               rsp_w_in = dn_q;
               am_in    = am_ff + SlotW'(1);
            end else if ((hi_ff == '1) || (du_ff > SlotW'(gis_pkg::MaxIds))) begin
               rsp_w_in      = '0;
               rsp_alive_in  = 1'b0;
               rsp_exists_in = 1'b0;
               rsp_valid_in  = 1'b0;
               rsp_status_in = 1'b1;
            end else begin
               rsp_w_in      = '{gen: '0, id: hi_ff + IdW'(1)};
               dn_port.we    = 1'b1;
               dn_port.waddr = du_ff;
               dn_port.wdata = '{gen: '0, id: hi_ff + IdW'(1)};
               sp_we         = 1'b1;
               sp_waddr      = hi_ff + IdW'(1);
               sp_wdata      = du_ff;
               hi_in         = hi_ff + IdW'(1);
               du_in         = du_ff + SlotW'(1);
               am_in         = am_ff + SlotW'(1);
            end
            state_in = ST_OUT;
         end
         ST_BAT_CHK: begin
            if (cnt_sat == '0) begin
               state_in = ST_IDLE;
            end else if ((nc >= du_ff) &&
                         ((mint_top >= SlotW'(gis_pkg::MaxIds)) ||
                          (nc > SlotW'(gis_pkg::DenseDepth)))) begin
               rsp_w_in      = '0;
               rsp_alive_in  = 1'b0;
               rsp_exists_in = 1'b0;
               rsp_valid_in  = 1'b0;
               rsp_status_in = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_OUT;
            end else begin
               nc_in    = nc;
               idx_in   = am_ff;
               am_in    = nc;
               state_in = (nc >= du_ff) ? ST_BAT_MINT : ST_BAT_RD;
            end
         end
         ST_BAT_MINT: begin
            if (du_ff != nc_ff) begin
               dn_port.we    = 1'b1;
               dn_port.waddr = du_ff;
               dn_port.wdata = '{gen: '0, id: hi_ff + IdW'(1)};
               sp_we         = 1'b1;
               sp_waddr      = hi_ff + IdW'(1);
               sp_wdata      = du_ff;
               hi_in         = hi_ff + IdW'(1);
               du_in         = du_ff + SlotW'(1);
            end else begin
               state_in = ST_BAT_RD;
            end
         end
         ST_BAT_RD: begin
            dn_port.raddr = idx_ff;
            state_in      = ST_BAT_Q;
         end
         ST_BAT_Q: begin
            rsp_w_in      = dn_q;
            rsp_alive_in  = 1'b1;
            rsp_exists_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_last_in   = (idx_ff + SlotW'(1) == nc_ff);
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + SlotW'(1);
                  state_in = ST_BAT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         am_ff      <= SlotW'(1);
         du_ff      <= SlotW'(1);
         hi_ff      <= '0;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         do_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         am_ff      <= am_in;
         du_ff      <= du_in;
         hi_ff      <= hi_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         do_ff      <= do_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      gen_ff        <= gen_in;
      cnt_ff        <= cnt_in;
      s_ff          <= s_in;
      nc_ff         <= nc_in;
      idx_ff        <= idx_in;
      w_ff          <= w_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_exists_ff <= rsp_exists_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");

   // the alive mark runs ahead of the dense count while a batch is being minted
   a_mark_order: assert property (@(posedge clock) disable iff (reset)
      (am_ff != '0) && ((state_ff == ST_BAT_MINT) || (am_ff <= du_ff)))
      else $error("alive mark outside dense range");

   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata[11:0] == '0)))
      else $error("full status with a nonzero id");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for generational_id_sparse_set_unit
// holds its own sparse set predictor, depends on gis_pkg and the rtl top level
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdW        = gis_pkg::IdW;
   localparam int GenW       = gis_pkg::GenW;
   localparam int SlotW      = gis_pkg::SlotW;
   localparam int CntW       = gis_pkg::CntW;
   localparam int MaxIds     = gis_pkg::MaxIds;
   localparam int MaxBatch   = gis_pkg::MaxBatch;
   localparam int DenseDepth = gis_pkg::DenseDepth;

   localparam logic [2:0] OpSpare = 3'd7;  // unused code, behaves as lookup

   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [GenW-1:0] gen;
      logic            alive;
      logic            exists;
      logic            valid;
      logic [11:0]     alive_total;
      logic [11:0]     dead_total;
      logic            full;
      logic            last;
   } rsp_item_type;

   typedef struct {
      logic [2:0]      op;
      logic [IdW-1:0]  id;
      logic [GenW-1:0] gen;
      logic [CntW-1:0] cnt;
      bit              typed;
      rsp_item_type    want;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // predictor copy of the set
   logic [SlotW-1:0] slot_of [MaxIds];
   logic [IdW-1:0]   dense_id [DenseDepth];
   logic [GenW-1:0]  dense_gen [DenseDepth];
   int               alive_mark;
   int               dense_used;
   int               highest_id;

   rsp_item_type pending_rsp[$];
   int           errors = 0;
   int           send_idle = 0;
   int           recv_idle = 0;

   generational_id_sparse_set_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic rsp_item_type make_rsp(int id, int gen, bit a, bit e, bit v, bit f,
                                             bit l);
      rsp_item_type r;
      r.id = id[IdW-1:0];
      r.gen = gen[GenW-1:0];
      r.alive = a;
      r.exists = e;
      r.valid = v;
      r.alive_total = 12'(alive_mark - 1);
      r.dead_total = 12'(dense_used - alive_mark);
      r.full = f;
      r.last = l;
      return r;
   endfunction

   function automatic int slot_lookup(int id);
      if (id == 0) return 0;
      return int'(slot_of[id]);
   endfunction

   function automatic void move_word(int dst, int src_id, int src_gen);
      dense_id[dst] = src_id[IdW-1:0];
      dense_gen[dst] = src_gen[GenW-1:0];
   endfunction

   function automatic void set_add(int id, int gen);
      int s;
      int sid;
      int sgen;
      s = slot_lookup(id);
      if (id == 0 || (s != 0 && s < alive_mark)) return;
      if (s == 0) begin
         if (dense_used > MaxIds) return;
         s = dense_used;
         dense_used++;
         move_word(s, id, gen);
         slot_of[id] = SlotW'(s);
         if (id > highest_id) highest_id = id;
      end
      sid = dense_id[alive_mark];
      sgen = dense_gen[alive_mark];
      slot_of[sid] = SlotW'(s);
      slot_of[id] = SlotW'(alive_mark);
      move_word(s, sid, sgen);
      move_word(alive_mark, id, gen);
      alive_mark++;
   endfunction

   function automatic void set_drop(int id, int gen);
      int s;
      int sid;
      int sgen;
      s = slot_lookup(id);
      if (s == 0 || s >= alive_mark) return;
      if (dense_id[s] != id || dense_gen[s] != gen) return;
      alive_mark--;
      sid = dense_id[alive_mark];
      sgen = dense_gen[alive_mark];
      slot_of[sid] = SlotW'(s);
      slot_of[id] = SlotW'(alive_mark);
      move_word(s, sid, sgen);
      move_word(alive_mark, id, (gen + 1) & 16'hffff);
   endfunction

   // queues the results one accepted transaction causes
   function automatic void predict_set(logic [2:0] op, int id, int gen, int cnt);
      int s;
      int start;
      int upto;
      bit v;
      case (op)
         gis_pkg::OP_NEW_ID: begin
            if (alive_mark != dense_used) begin
               s = alive_mark;
               alive_mark++;
            end else begin
               if (highest_id + 1 >= MaxIds || dense_used > MaxIds) begin
                  pending_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1, 1));
                  return;
               end
               highest_id++;
               s = dense_used;
               move_word(s, highest_id, 0);
               slot_of[highest_id] = SlotW'(s);
               dense_used++;
               alive_mark++;
            end
            pending_rsp.push_back(make_rsp(dense_id[s], dense_gen[s], 1, 1, 1, 0, 1));
            return;
         end
         gis_pkg::OP_NEW_IDS: begin
            if (cnt > MaxBatch) cnt = MaxBatch;
            if (cnt == 0) return;
            start = alive_mark;
            upto = alive_mark + cnt;
            if (upto >= dense_used) begin
               if (highest_id + upto - dense_used >= MaxIds || upto > MaxIds + 1) begin
                  pending_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1, 1));
                  return;
               end
               for (int k = dense_used; k < upto; k++) begin
                  highest_id++;
                  move_word(k, highest_id, 0);
                  slot_of[highest_id] = SlotW'(k);
               end
               dense_used = upto;
            end
            alive_mark = upto;
            for (int k = 0; k < cnt; k++)
               pending_rsp.push_back(make_rsp(dense_id[start+k], dense_gen[start+k], 1, 1, 1,
                                              0, k + 1 == cnt));
            return;
         end
         gis_pkg::OP_ENSURE: set_add(id, gen);
         gis_pkg::OP_REMOVE: set_drop(id, gen);
         gis_pkg::OP_MAKE_ALIVE: begin
            s = slot_lookup(id);
            if (s != 0) move_word(s, id, gen);
         end
         gis_pkg::OP_CLEAR: begin
            foreach (slot_of[k]) slot_of[k] = '0;
            alive_mark = 1;
            dense_used = 1;
            highest_id = 0;
            pending_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 0, 1));
            return;
         end
         default: ;
      endcase
      s = slot_lookup(id);
      if (s == 0) begin
         pending_rsp.push_back(make_rsp(0, 0, 0, 0, 1, 0, 1));
      end else begin
         v = s < alive_mark;
         pending_rsp.push_back(make_rsp(dense_id[s], dense_gen[s],
                                        v && dense_id[s] == id && dense_gen[s] == gen,
                                        1, v, 0, 1));
      end
   endfunction

   task automatic send_op(logic [2:0] op, int id, int gen, int cnt, bit typed = 0,
                          rsp_item_type want = '{default: 0});
      int before_q;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b0, cnt[CntW-1:0], gen[GenW-1:0], id[IdW-1:0], op};
      do @(posedge clock); while (!req_tready);
      before_q = pending_rsp.size();
      predict_set(op, id, gen, cnt);
      if (typed) begin
         while (pending_rsp.size() > before_q) void'(pending_rsp.pop_back());
         pending_rsp.push_back(want);
      end
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // receiver stalls and result checking
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type exp_r;
      rsp_tready <= ($urandom_range(99) >= recv_idle);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.id = rsp_tdata[11:0];
         got.gen = rsp_tdata[27:12];
         got.alive = rsp_tdata[28];
         got.exists = rsp_tdata[29];
         got.valid = rsp_tdata[30];
         got.alive_total = rsp_tdata[42:31];
         got.dead_total = rsp_tdata[54:43];
         got.full = rsp_tuser;
         got.last = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected transaction, actual %p", $realtime, got);
            errors++;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (got !== exp_r) begin
               $display("%0t mismatch, expected %p actual %p", $realtime, exp_r, got);
               errors++;
            end
         end
      end
   end

   function automatic int pick_id();
      int top;
      top = (highest_id + 3 > MaxIds - 1) ? MaxIds - 1 : highest_id + 3;
      if ($urandom_range(9) < 8) return $urandom_range(top, 1);
      return $urandom_range(MaxIds - 1);
   endfunction

   function automatic int pick_gen(int id);
      int s;
      s = slot_lookup(id);
      if (s != 0 && $urandom_range(9) < 6) return dense_gen[s];
      return $urandom_range(16'hffff);
   endfunction

   task automatic random_ops(int n);
      int r;
      int id;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         id = pick_id();
         if (r < 12) send_op(gis_pkg::OP_NEW_ID, id, $urandom_range(16'hffff),
                             $urandom_range(127));
         else if (r < 22)
            send_op(gis_pkg::OP_NEW_IDS, id, $urandom_range(16'hffff),
                    ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8, 1));
         else if (r < 44) send_op(gis_pkg::OP_ENSURE, id, pick_gen(id), $urandom_range(127));
         else if (r < 66) send_op(gis_pkg::OP_REMOVE, id, pick_gen(id), $urandom_range(127));
         else if (r < 82) send_op(gis_pkg::OP_LOOKUP, id, pick_gen(id), $urandom_range(127));
         else if (r < 92) send_op(gis_pkg::OP_MAKE_ALIVE, id, $urandom_range(16'hffff),
                                  $urandom_range(127));
         else if (r < 98) send_op(OpSpare, id, pick_gen(id), $urandom_range(127));
         else begin
            drain_wait();
            send_op(gis_pkg::OP_CLEAR, id, $urandom_range(16'hffff), $urandom_range(127));
         end
      end
   endtask

   initial begin
      stim_row_type rows[$];
      rsp_item_type unknown_rsp;
      rsp_item_type first_rsp;
      rsp_item_type cleared_rsp;
      unknown_rsp = '{id: 0, gen: 0, alive: 0, exists: 0, valid: 1, alive_total: 0,
                      dead_total: 0, full: 0, last: 1};
      first_rsp = '{id: 1, gen: 0, alive: 1, exists: 1, valid: 1, alive_total: 1,
                    dead_total: 0, full: 0, last: 1};
      cleared_rsp = '{id: 0, gen: 0, alive: 0, exists: 0, valid: 0, alive_total: 0,
                      dead_total: 0, full: 0, last: 1};
      rows = '{
         '{gis_pkg::OP_LOOKUP, 0, 0, 0, 1, unknown_rsp},
         '{gis_pkg::OP_LOOKUP, 4095, 16'hffff, 7'h7f, 1, unknown_rsp},
         '{gis_pkg::OP_NEW_ID, 0, 0, 0, 1, first_rsp},
         '{gis_pkg::OP_NEW_IDS, 0, 0, 3, 0, unknown_rsp},
         '{gis_pkg::OP_NEW_IDS, 0, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_ENSURE, 0, 7, 0, 0, unknown_rsp},
         '{gis_pkg::OP_ENSURE, 10, 16'hffff, 0, 0, unknown_rsp},
         '{gis_pkg::OP_ENSURE, 10, 5, 0, 0, unknown_rsp},
         '{gis_pkg::OP_REMOVE, 10, 1, 0, 0, unknown_rsp},
         '{gis_pkg::OP_REMOVE, 10, 16'hffff, 0, 0, unknown_rsp},
         '{gis_pkg::OP_LOOKUP, 10, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_ENSURE, 10, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_MAKE_ALIVE, 2, 16'h1234, 0, 0, unknown_rsp},
         '{gis_pkg::OP_MAKE_ALIVE, 0, 16'h1234, 0, 0, unknown_rsp},
         '{gis_pkg::OP_REMOVE, 2, 16'h1234, 0, 0, unknown_rsp},
         '{gis_pkg::OP_NEW_ID, 0, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_REMOVE, 0, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_NEW_IDS, 0, 0, 7'h7f, 0, unknown_rsp},
         '{OpSpare, 3, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_LOOKUP, 4095, 0, 0, 0, unknown_rsp},
         '{gis_pkg::OP_CLEAR, 0, 0, 0, 1, cleared_rsp},
         '{gis_pkg::OP_LOOKUP, 1, 0, 0, 0, unknown_rsp}
      };
      foreach (slot_of[k]) slot_of[k] = '0;
      alive_mark = 1;
      dense_used = 1;
      highest_id = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle = 19;
      recv_idle = 75;
      foreach (rows[k]) begin
         if (rows[k].op == gis_pkg::OP_CLEAR) drain_wait();
         send_op(rows[k].op, rows[k].id, rows[k].gen, rows[k].cnt, rows[k].typed,
                 rows[k].want);
      end
      random_ops(110);
      drain_wait();

      send_idle = 75;
      recv_idle = 19;
      random_ops(110);
      drain_wait();

      send_idle = 0;
      recv_idle = 0;
      random_ops(40);
      // fill the id space until minting runs out
      drain_wait();
      send_op(gis_pkg::OP_CLEAR, 0, 0, 0);
      for (int k = 0; k < 64; k++) send_op(gis_pkg::OP_NEW_IDS, 0, 0, 64);
      send_op(gis_pkg::OP_NEW_IDS, 0, 0, 63);
      send_op(gis_pkg::OP_NEW_ID, 0, 0, 0);
      send_op(gis_pkg::OP_REMOVE, 4095, 0, 0);
      send_op(gis_pkg::OP_NEW_ID, 0, 0, 0);
      send_op(gis_pkg::OP_NEW_ID, 0, 0, 0);
      send_op(gis_pkg::OP_ENSURE, 4095, 16'hffff, 0);
      send_op(gis_pkg::OP_LOOKUP, 4095, 16'hffff, 0);
      random_ops(20);
      drain_wait();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
